### sv/sfd_pkg.sv
// Shared types and constants of the sensor frame deframer.
`timescale 1ns / 1ps

package sfd_pkg;

  localparam int STORE_BYTES_DEF = 20;
  localparam int FRAME_BYTES     = 17;

  localparam logic [7:0] HDR0 = 8'hA0;
  localparam logic [7:0] HDR1 = 8'h0A;
  localparam logic [7:0] TRL0 = 8'h0A;
  localparam logic [7:0] TRL1 = 8'hA0;

  localparam int POS_SUM_FIRST = 2;
  localparam int POS_NODE      = 3;
  localparam int POS_LIGHT_HI  = 4;
  localparam int POS_LIGHT_LO  = 5;
  localparam int POS_MOTION    = 6;
  localparam int POS_REED      = 7;
  localparam int POS_TEMP      = 8;
  localparam int POS_SUM_END   = 14;
  localparam int POS_CHK       = 14;
  localparam int POS_TRL0      = FRAME_BYTES - 2;
  localparam int POS_TRL1      = FRAME_BYTES - 1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_CHK = 2'd1,
    ST_HDR = 2'd2,
    ST_OVF = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    KIND_FRAME   = 2'd0,
    KIND_HDR_ERR = 2'd1,
    KIND_OVF     = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  sum;
    logic [7:0]  chk;
    logic [7:0]  node_id;
    logic [15:0] light_level;
    logic [7:0]  motion;
    logic [7:0]  reed_switch;
    logic [7:0]  temperature;
  } rec_t;

endpackage

### sv/sfd_front.sv
// Front end: takes bytes, tracks the frame position and emits one record per event.
`timescale 1ns / 1ps

module sfd_front #(
  parameter int STORE_BYTES = sfd_pkg::STORE_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic [7:0]    rx_byte,
  output logic          push,
  output sfd_pkg::rec_t rec
);

  localparam int CNT_W = $clog2(STORE_BYTES + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             hdr_seen_r, hdr_seen_nxt;
  logic [7:0]       byte0_r, byte0_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       chk_r, chk_nxt;
  logic             trl_ok_r, trl_ok_nxt;
  logic [7:0]       node_r, node_nxt;
  logic [7:0]       light_hi_r, light_hi_nxt;
  logic [7:0]       light_lo_r, light_lo_nxt;
  logic [7:0]       motion_r, motion_nxt;
  logic [7:0]       reed_r, reed_nxt;
  logic [7:0]       temp_r, temp_nxt;

  always_comb begin
    count_nxt    = count_r;
    hdr_seen_nxt = hdr_seen_r;
    byte0_nxt    = byte0_r;
    sum_nxt      = sum_r;
    chk_nxt      = chk_r;
    trl_ok_nxt   = trl_ok_r;
    node_nxt     = node_r;
    light_hi_nxt = light_hi_r;
    light_lo_nxt = light_lo_r;
    motion_nxt   = motion_r;
    reed_nxt     = reed_r;
    temp_nxt     = temp_r;
    push         = 1'b0;
    rec.kind        = sfd_pkg::KIND_FRAME;
    rec.sum         = sum_r;
    rec.chk         = chk_r;
    rec.node_id     = node_r;
    rec.light_level = {light_hi_r, light_lo_r};
    rec.motion      = motion_r;
    rec.reed_switch = reed_r;
    rec.temperature = temp_r;
    if (in_fire) begin
      if (!hdr_seen_r) begin
        if (count_r == '0) begin
          byte0_nxt = rx_byte;
          count_nxt = CNT_W'(1);
        end else if (byte0_r == sfd_pkg::HDR0 && rx_byte == sfd_pkg::HDR1) begin
          hdr_seen_nxt = 1'b1;
          count_nxt    = CNT_W'(2);
        end else begin
          count_nxt = '0;
          push      = 1'b1;
          rec.kind  = sfd_pkg::KIND_HDR_ERR;
        end
      end else begin
        if (count_r == CNT_W'(sfd_pkg::POS_SUM_FIRST)) begin
          sum_nxt = rx_byte;
        end else if (count_r > CNT_W'(sfd_pkg::POS_SUM_FIRST) &&
                     count_r < CNT_W'(sfd_pkg::POS_SUM_END)) begin
          sum_nxt = sum_r + rx_byte;
        end
        if (count_r == CNT_W'(sfd_pkg::POS_NODE))     node_nxt     = rx_byte;
        if (count_r == CNT_W'(sfd_pkg::POS_LIGHT_HI)) light_hi_nxt = rx_byte;
        if (count_r == CNT_W'(sfd_pkg::POS_LIGHT_LO)) light_lo_nxt = rx_byte;
        if (count_r == CNT_W'(sfd_pkg::POS_MOTION))   motion_nxt   = rx_byte;
        if (count_r == CNT_W'(sfd_pkg::POS_REED))     reed_nxt     = rx_byte;
        if (count_r == CNT_W'(sfd_pkg::POS_TEMP))     temp_nxt     = rx_byte;
        if (count_r == CNT_W'(sfd_pkg::POS_CHK))      chk_nxt      = rx_byte;
        if (count_r == CNT_W'(sfd_pkg::POS_TRL0)) begin
          trl_ok_nxt = (rx_byte == sfd_pkg::TRL0);
        end
        if (count_r == CNT_W'(sfd_pkg::POS_TRL1) && trl_ok_r &&
            rx_byte == sfd_pkg::TRL1) begin
          count_nxt    = '0;
          hdr_seen_nxt = 1'b0;
          push         = 1'b1;
          rec.kind     = sfd_pkg::KIND_FRAME;
        end else if (count_r == CNT_W'(STORE_BYTES - 1)) begin
          count_nxt    = '0;
          hdr_seen_nxt = 1'b0;
          push         = 1'b1;
          rec.kind     = sfd_pkg::KIND_OVF;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      hdr_seen_r <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      hdr_seen_r <= hdr_seen_nxt;
    end
    byte0_r    <= byte0_nxt;
    sum_r      <= sum_nxt;
    chk_r      <= chk_nxt;
    trl_ok_r   <= trl_ok_nxt;
    node_r     <= node_nxt;
    light_hi_r <= light_hi_nxt;
    light_lo_r <= light_lo_nxt;
    motion_r   <= motion_nxt;
    reed_r     <= reed_nxt;
    temp_r     <= temp_nxt;
  end

endmodule

### sv/sfd_queue.sv
// Short record queue between the front end and the result stage.
`timescale 1ns / 1ps

module sfd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sfd_pkg::rec_t push_rec,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output sfd_pkg::rec_t head_rec
);

  sfd_pkg::rec_t                    entry_r [sfd_pkg::QDEPTH];
  logic [sfd_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [sfd_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [sfd_pkg::QCNT_W-1:0]       fill_r, fill_nxt;
  logic                             do_push, do_pop;

  assign full     = (fill_r == sfd_pkg::QCNT_W'(sfd_pkg::QDEPTH));
  assign q_valid  = (fill_r != '0);
  assign head_rec = entry_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == sfd_pkg::QPTR_W'(sfd_pkg::QDEPTH - 1)) ? '0
                   : wr_ptr_r + sfd_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == sfd_pkg::QPTR_W'(sfd_pkg::QDEPTH - 1)) ? '0
                   : rd_ptr_r + sfd_pkg::QPTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   fill_nxt = fill_r + sfd_pkg::QCNT_W'(1);
      2'b01:   fill_nxt = fill_r - sfd_pkg::QCNT_W'(1);
      default: fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

### sv/sfd_back.sv
// Result stage: checks the checksum, forms the status and holds the output register.
`timescale 1ns / 1ps

module sfd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  sfd_pkg::rec_t head_rec,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_status,
  output logic [7:0]    out_node_id,
  output logic [15:0]   out_light_level,
  output logic [7:0]    out_motion,
  output logic [7:0]    out_reed_switch,
  output logic [7:0]    out_temperature
);

  logic              valid_r, valid_nxt;
  sfd_pkg::status_t  status_r, status_nxt;
  logic [7:0]        node_r, node_nxt;
  logic [15:0]       light_r, light_nxt;
  logic [7:0]        motion_r, motion_nxt;
  logic [7:0]        reed_r, reed_nxt;
  logic [7:0]        temp_r, temp_nxt;
  logic              is_frame;

  assign pop      = q_valid && (!valid_r || out_ready);
  assign is_frame = (head_rec.kind == sfd_pkg::KIND_FRAME);

  always_comb begin
    valid_nxt  = valid_r;
    status_nxt = status_r;
    node_nxt   = node_r;
    light_nxt  = light_r;
    motion_nxt = motion_r;
    reed_nxt   = reed_r;
    temp_nxt   = temp_r;
    if (pop) begin
      valid_nxt = 1'b1;
      case (head_rec.kind)
        sfd_pkg::KIND_FRAME: begin
          status_nxt = (head_rec.sum == head_rec.chk) ? sfd_pkg::ST_OK : sfd_pkg::ST_CHK;
        end
        sfd_pkg::KIND_HDR_ERR: status_nxt = sfd_pkg::ST_HDR;
        default:               status_nxt = sfd_pkg::ST_OVF;
      endcase
      node_nxt   = is_frame ? head_rec.node_id     : 8'd0;
      light_nxt  = is_frame ? head_rec.light_level : 16'd0;
      motion_nxt = is_frame ? head_rec.motion      : 8'd0;
      reed_nxt   = is_frame ? head_rec.reed_switch : 8'd0;
      temp_nxt   = is_frame ? head_rec.temperature : 8'd0;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    status_r <= status_nxt;
    node_r   <= node_nxt;
    light_r  <= light_nxt;
    motion_r <= motion_nxt;
    reed_r   <= reed_nxt;
    temp_r   <= temp_nxt;
  end

  assign out_valid       = valid_r;
  assign out_status      = status_r;
  assign out_node_id     = node_r;
  assign out_light_level = light_r;
  assign out_motion      = motion_r;
  assign out_reed_switch = reed_r;
  assign out_temperature = temp_r;

endmodule

### sv/sensor_frame_deframer.sv
// Top level of the sensor frame deframer.
// Usage: received bytes enter on in_valid/in_ready/in_rx_byte, one item per cycle while in_ready is high.
// Frames are A0 0A, payload, checksum at byte 14, then 0A A0, seventeen bytes in all.
// Results leave on out_valid/out_ready with status, node id, light level, motion,
// reed switch and temperature; status 0 is a good frame, 1 a checksum error,
// 2 a bad header (data fields zero) and 3 an overflow (data fields zero).
// Most bytes produce no result; the byte that completes or aborts a frame, once
// accepted, writes a result into the queue, from which it reaches the output register.
// Throughput is one byte per cycle while the queue is not full, set by the front end;
// a two-item queue and the output register decouple it from the receiver.
// When the receiver stalls, results collect in the queue; in_ready falls only
// when that queue is full, and no item is lost or repeated.
// Reset clears the byte count, the header flag, the queue and the output valid;
// the block accepts bytes as soon as reset is released.
`timescale 1ns / 1ps

module sensor_frame_deframer #(
  parameter int STORE_BYTES = sfd_pkg::STORE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [7:0]  out_node_id,
  output logic [15:0] out_light_level,
  output logic [7:0]  out_motion,
  output logic [7:0]  out_reed_switch,
  output logic [7:0]  out_temperature
);

  logic          in_fire;
  logic          push;
  logic          full;
  logic          pop;
  logic          q_valid;
  sfd_pkg::rec_t push_rec;
  sfd_pkg::rec_t head_rec;

  assign in_ready = !full;
  assign in_fire  = in_valid && in_ready;

  sfd_front #(
    .STORE_BYTES(STORE_BYTES)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .rx_byte (in_rx_byte),
    .push    (push),
    .rec     (push_rec)
  );

  sfd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .full     (full),
    .pop      (pop),
    .q_valid  (q_valid),
    .head_rec (head_rec)
  );

  sfd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .head_rec        (head_rec),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_node_id     (out_node_id),
    .out_light_level (out_light_level),
    .out_motion      (out_motion),
    .out_reed_switch (out_reed_switch),
    .out_temperature (out_temperature)
  );

endmodule

### tb/tb_sensor_frame_deframer.sv
// Self-checking testbench of the sensor frame deframer with a frame predictor and random stalls.
`timescale 1ns / 1ps

module tb_sensor_frame_deframer;
  import sfd_pkg::*;

  localparam int ITEMS_TOTAL    = 1850;
  localparam int HOLD_CYCLES    = 120;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    status_t     status;
    logic [7:0]  node_id;
    logic [15:0] light_level;
    logic [7:0]  motion;
    logic [7:0]  reed_switch;
    logic [7:0]  temperature;
  } frame_result_t;

  typedef enum int {
    SEQ_GOOD,
    SEQ_EXTREMES,
    SEQ_BAD_SUM,
    SEQ_INNER_TRAILER,
    SEQ_BAD_TRAILER,
    SEQ_RUNAWAY,
    SEQ_BAD_HEADER,
    SEQ_NOISE
  } seq_kind_t;

  class frame_result_board;
    logic [7:0]    store [STORE_BYTES_DEF];
    logic [4:0]    held;
    logic          hdr_seen;
    frame_result_t pending_results [$];
    int            faults;
    int            seen [4];

    function new();
      held     = '0;
      hdr_seen = 1'b0;
      faults   = 0;
      foreach (seen[i]) seen[i] = 0;
    endfunction

    function void take_byte(input logic [7:0] b);
      frame_result_t r;
      logic [7:0]    sum;
      r = '0;
      if (held >= STORE_BYTES_DEF) begin
        held     = '0;
        hdr_seen = 1'b0;
      end
      store[held] = b;
      held        = held + 5'd1;
      if (hdr_seen) begin
        if (held == FRAME_BYTES && store[POS_TRL0] == TRL0 && store[POS_TRL1] == TRL1) begin
          sum = '0;
          for (int i = POS_SUM_FIRST; i < POS_SUM_END; i++) sum = sum + store[i];
          r.status      = (sum == store[POS_CHK]) ? ST_OK : ST_CHK;
          r.node_id     = store[POS_NODE];
          r.light_level = {store[POS_LIGHT_HI], store[POS_LIGHT_LO]};
          r.motion      = store[POS_MOTION];
          r.reed_switch = store[POS_REED];
          r.temperature = store[POS_TEMP];
          held          = '0;
          hdr_seen      = 1'b0;
          pending_results.push_back(r);
        end else if (held >= STORE_BYTES_DEF) begin
          r.status = ST_OVF;
          held     = '0;
          hdr_seen = 1'b0;
          pending_results.push_back(r);
        end
      end else if (held >= 2) begin
        if (store[0] == HDR0 && store[1] == HDR1) begin
          hdr_seen = 1'b1;
        end else begin
          r.status = ST_HDR;
          held     = '0;
          pending_results.push_back(r);
        end
      end
    endfunction

    function void compare_field(input string what, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) begin
        faults++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      end
    endfunction

    function void check_result(input logic [1:0] st, input logic [7:0] node,
                               input logic [15:0] light, input logic [7:0] mot,
                               input logic [7:0] reed, input logic [7:0] temp);
      frame_result_t want;
      if (pending_results.size() == 0) begin
        faults++;
        $display("%0t: result with status %0d arrived with nothing expected", $time, st);
        return;
      end
      want = pending_results.pop_front();
      seen[want.status]++;
      compare_field("status", 16'(want.status), 16'(st));
      compare_field("node_id", 16'(want.node_id), 16'(node));
      compare_field("light_level", want.light_level, light);
      compare_field("motion", 16'(want.motion), 16'(mot));
      compare_field("reed_switch", 16'(want.reed_switch), 16'(reed));
      compare_field("temperature", 16'(want.temperature), 16'(temp));
    endfunction
  endclass

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [1:0]  out_status;
  logic [7:0]  out_node_id;
  logic [15:0] out_light_level;
  logic [7:0]  out_motion;
  logic [7:0]  out_reed_switch;
  logic [7:0]  out_temperature;

  frame_result_board board;
  logic [7:0]        frame_buf [FRAME_BYTES];
  int                bytes_sent   = 0;
  int                snd_idle_pct = 0;
  int                rcv_idle_pct = 0;
  bit                hold_req     = 1'b0;

  sensor_frame_deframer i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_node_id     (out_node_id),
    .out_light_level (out_light_level),
    .out_motion      (out_motion),
    .out_reed_switch (out_reed_switch),
    .out_temperature (out_temperature)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.take_byte(b);
    bytes_sent++;
  endtask

  function automatic logic [7:0] pick_payload();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] payload_sum();
    logic [7:0] sum;
    sum = '0;
    for (int i = POS_SUM_FIRST; i < POS_SUM_END; i++) sum = sum + frame_buf[i];
    return sum;
  endfunction

  function automatic seq_kind_t pick_kind();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return SEQ_GOOD;
    if (roll < 50) return SEQ_BAD_SUM;
    if (roll < 60) return SEQ_INNER_TRAILER;
    if (roll < 70) return SEQ_BAD_TRAILER;
    if (roll < 75) return SEQ_RUNAWAY;
    if (roll < 87) return SEQ_BAD_HEADER;
    return SEQ_NOISE;
  endfunction

  task automatic send_frame(input seq_kind_t k);
    int p;
    // Realign with the frame boundary so that the sequence starts a fresh header search.
    while (board.held != 0) send_byte(8'($urandom_range(0, 255)));
    case (k)
      SEQ_NOISE: begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end
      SEQ_BAD_HEADER: begin
        if ($urandom_range(0, 1)) begin
          send_byte(HDR0);
          send_byte(HDR1 ^ 8'($urandom_range(1, 255)));
        end else begin
          send_byte(HDR0 ^ 8'($urandom_range(1, 255)));
          send_byte(HDR1);
        end
      end
      default: begin
        frame_buf[0] = HDR0;
        frame_buf[1] = HDR1;
        for (p = POS_SUM_FIRST; p < POS_SUM_END; p++) begin
          if (k == SEQ_EXTREMES) frame_buf[p] = (p % 2) ? 8'hFF : 8'h00;
          else frame_buf[p] = pick_payload();
        end
        if (k == SEQ_INNER_TRAILER) begin
          p                = $urandom_range(POS_SUM_FIRST, POS_SUM_END - 2);
          frame_buf[p]     = TRL0;
          frame_buf[p + 1] = TRL1;
        end
        frame_buf[POS_CHK] = payload_sum();
        if (k == SEQ_BAD_SUM) frame_buf[POS_CHK] = frame_buf[POS_CHK] + 8'($urandom_range(1, 255));
        frame_buf[POS_TRL0] = TRL0;
        frame_buf[POS_TRL1] = TRL1;
        if (k == SEQ_RUNAWAY) begin
          for (p = POS_SUM_FIRST; p < FRAME_BYTES; p++) frame_buf[p] = 8'($urandom_range(0, 255));
        end
        if (k == SEQ_BAD_TRAILER) begin
          frame_buf[POS_TRL0] = 8'($urandom_range(0, 255));
          frame_buf[POS_TRL1] = 8'($urandom_range(0, 255));
          if (frame_buf[POS_TRL0] == TRL0 && frame_buf[POS_TRL1] == TRL1)
            frame_buf[POS_TRL1] = frame_buf[POS_TRL1] ^ 8'h01;
        end
        for (p = 0; p < FRAME_BYTES; p++) send_byte(frame_buf[p]);
        if (k == SEQ_BAD_TRAILER || k == SEQ_RUNAWAY)
          repeat (STORE_BYTES_DEF - FRAME_BYTES) send_byte(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_result(out_status, out_node_id, out_light_level, out_motion,
                         out_reed_switch, out_temperature);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int ph;
    board = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(TRL0);
    send_byte(TRL1);
    send_byte(HDR0);
    send_byte(HDR0);
    send_frame(SEQ_EXTREMES);

    for (ph = 0; ph < 3; ph++) begin
      snd_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 51 : 0;
      rcv_idle_pct = (ph == 0) ? 51 : (ph == 1) ? 23 : 0;
      if (ph == 2) begin
        // The receiver stops for a long stretch while bytes keep coming, so the output
        // queue fills and the input has to stall.
        hold_req = 1'b1;
        repeat (40) send_byte(8'($urandom_range(0, 255)));
      end
      while (bytes_sent < (ph + 1) * ITEMS_TOTAL / 3) send_frame(pick_kind());
    end
    in_valid <= 1'b0;

    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes under three stall mixes, including one long receiver hold.",
             bytes_sent);
    $display("Results checked: %0d good, %0d checksum, %0d header, %0d overflow.",
             board.seen[ST_OK], board.seen[ST_CHK], board.seen[ST_HDR], board.seen[ST_OVF]);
    if (board.faults == 0 && board.pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
